@@ hw/rtl/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

   // Timers that a three-bit index can address
   localparam int MAX_TIMERS         = 8;
   localparam int INDEX_WIDTH        = 3;
   localparam int TICK_WIDTH         = 32;
   localparam int TIMEOUT_WIDTH      = 24;
   localparam int NUM_TIMERS_DEFAULT = 8;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_TICK  = 2'd2,
      OP_SCAN  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [INDEX_WIDTH-1:0]     timer_index;
      logic [TIMEOUT_WIDTH-1:0]   timeout_ticks;
      logic                       periodic;
   } req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] fired_index;
      logic                   fired;
      logic                   last;
   } rsp_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } back_state_type;

endpackage

@@ hw/rtl/software_timer_bank_unit.sv @@
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// Start, stop and tick wait in the command queue after acceptance and take
// effect when the back end pops them in idle, which they do not leave.
// A scan walks min(NUM_TIMERS, 8) timers, one timer checked per cycle, and
// then closes with its last result.
// A two-entry command queue decouples acceptance; busy rises when it is full.
// Synchronous reset clears the counter, all timers and the queue at once.
// ----------------------------------------------------------------------------
module software_timer_bank_unit #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stb_pkg::req_type req_data,
   output logic             rsp_strobe,
   output stb_pkg::rsp_type rsp_data
);

   stb_pkg::queue_status_type q_status;
   stb_pkg::req_type          push_data;
   stb_pkg::req_type          pop_data;
   logic                      push;
   logic                      pop;

   // Classify and accept
   stb_front #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_front (
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // Buffer commands
   stb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   // Execute
   stb_back #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .cmd        (pop_data),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hw/rtl/stb_front.sv @@
// ----------------------------------------------------------------------------
// stb_front
// Accepts command items, drops start and stop items aimed beyond the bank
// and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module stb_front #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                     start,
   output logic                     busy,
   input  stb_pkg::req_type         req_data,
   input  stb_pkg::queue_status_type q_status,
   output logic                     push,
   output stb_pkg::req_type         push_data
);

   localparam logic [6:0] Limit = 7'(NUM_TIMERS);

   logic in_range;
   logic keep;

   // Classify: timer commands must address an existing timer
   always_comb begin
      in_range = {4'b0, req_data.timer_index} < Limit;
      case (req_data.op)
         stb_pkg::OP_START: keep = in_range;
         stb_pkg::OP_STOP:  keep = in_range;
         stb_pkg::OP_TICK:  keep = 1'b1;
         stb_pkg::OP_SCAN:  keep = 1'b1;
         default:           keep = 1'b0;
      endcase
   end

   // Hold off new items while the queue is full
   assign busy      = q_status.full;
   assign push      = start && !q_status.full && keep;
   assign push_data = req_data;

endmodule

@@ hw/rtl/stb_queue.sv @@
// ----------------------------------------------------------------------------
// stb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module stb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  stb_pkg::req_type          push_data,
   input  logic                      pop,
   output stb_pkg::req_type          pop_data,
   output stb_pkg::queue_status_type q_status
);

   localparam int Depth  = stb_pkg::QUEUE_DEPTH;
   localparam int PtrW   = $clog2(Depth);
   localparam int CountW = $clog2(Depth + 1);

   stb_pkg::req_type  entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.full  = count_ff == CountW'(Depth);
   assign q_status.empty = count_ff == '0;
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_data       = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/stb_back.sv @@
// ----------------------------------------------------------------------------
// stb_back
// Carries out queued commands: keeps the tick counter and the timer file,
// and walks the timers one a cycle on a scan, reporting expiries.
// ----------------------------------------------------------------------------
module stb_back #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  stb_pkg::queue_status_type q_status,
   input  stb_pkg::req_type          cmd,
   output logic                      pop,
   output logic                      rsp_strobe,
   output stb_pkg::rsp_type          rsp_data
);

   localparam int IdxW  = stb_pkg::INDEX_WIDTH;
   localparam int TickW = stb_pkg::TICK_WIDTH;
   localparam int TmoW  = stb_pkg::TIMEOUT_WIDTH;
   localparam int Slots = stb_pkg::MAX_TIMERS;
   localparam int ActiveTimers = (NUM_TIMERS < Slots) ? NUM_TIMERS : Slots;
   localparam logic [IdxW-1:0] LastPtr = IdxW'(ActiveTimers - 1);

   stb_pkg::back_state_type state_ff, state_in;

   logic [TickW-1:0] tick_ff, tick_in;
   logic [TickW-1:0] start_ff   [Slots];
   logic [TickW-1:0] start_in   [Slots];
   logic [TmoW-1:0]  timeout_ff [Slots];
   logic [TmoW-1:0]  timeout_in [Slots];
   logic             mode_ff    [Slots];
   logic             mode_in    [Slots];
   logic [IdxW-1:0]  ptr_ff, ptr_in;
   logic [IdxW-1:0]  pend_idx_ff, pend_idx_in;
   logic             pend_vld_ff, pend_vld_in;

   logic [TickW-1:0] elapsed;
   logic             hit;
   logic             scanning;

   // Check the timer under the scan pointer
   assign elapsed  = tick_ff - start_ff[ptr_ff];
   assign hit      = (timeout_ff[ptr_ff] != '0) &&
                     (elapsed >= {{(TickW - TmoW){1'b0}}, timeout_ff[ptr_ff]});
   assign scanning = state_ff == stb_pkg::ST_SCAN;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stb_pkg::ST_IDLE: begin
            if (!q_status.empty && cmd.op == stb_pkg::OP_SCAN) begin
               state_in = stb_pkg::ST_SCAN;
            end
         end
         stb_pkg::ST_SCAN: begin
            if (ptr_ff == LastPtr) begin
               state_in = stb_pkg::ST_FINISH;
            end
         end
         stb_pkg::ST_FINISH: state_in = stb_pkg::ST_IDLE;
         default:            state_in = stb_pkg::ST_IDLE;
      endcase
   end

   // Outputs: pop in idle, emit the held expiry when a newer one turns up,
   // and close the scan with the held expiry or an empty result
   always_comb begin
      pop        = 1'b0;
      rsp_strobe = 1'b0;
      rsp_data   = '{fired_index: pend_idx_ff, fired: 1'b1, last: 1'b0};
      case (state_ff)
         stb_pkg::ST_IDLE: pop = !q_status.empty;
         stb_pkg::ST_SCAN: rsp_strobe = hit && pend_vld_ff;
         stb_pkg::ST_FINISH: begin
            rsp_strobe = 1'b1;
            if (pend_vld_ff) begin
               rsp_data = '{fired_index: pend_idx_ff, fired: 1'b1, last: 1'b1};
            end else begin
               rsp_data = '{fired_index: '0, fired: 1'b0, last: 1'b1};
            end
         end
         default: ;
      endcase
   end

   // Datapath updates for commands and scan steps
   always_comb begin
      tick_in     = tick_ff;
      start_in    = start_ff;
      timeout_in  = timeout_ff;
      mode_in     = mode_ff;
      ptr_in      = ptr_ff;
      pend_idx_in = pend_idx_ff;
      pend_vld_in = pend_vld_ff;
      if (pop) begin
         case (cmd.op)
            stb_pkg::OP_START: begin
               mode_in[cmd.timer_index]    = cmd.periodic;
               timeout_in[cmd.timer_index] = cmd.timeout_ticks;
               start_in[cmd.timer_index]   = tick_ff;
            end
            stb_pkg::OP_STOP: timeout_in[cmd.timer_index] = '0;
            stb_pkg::OP_TICK: tick_in = tick_ff + 1'b1;
            stb_pkg::OP_SCAN: begin
               ptr_in      = '0;
               pend_vld_in = 1'b0;
            end
            default: ;
         endcase
      end
      if (scanning) begin
         ptr_in = ptr_ff + 1'b1;
         if (hit) begin
            pend_idx_in = ptr_ff;
            pend_vld_in = 1'b1;
            // Restart a periodic timer, drop a one-shot one
            if (mode_ff[ptr_ff]) begin
               start_in[ptr_ff] = tick_ff;
            end else begin
               timeout_in[ptr_ff] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= stb_pkg::ST_IDLE;
         tick_ff     <= '0;
         ptr_ff      <= '0;
         pend_vld_ff <= 1'b0;
         for (int i = 0; i < Slots; i++) begin
            start_ff[i]   <= '0;
            timeout_ff[i] <= '0;
            mode_ff[i]    <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         ptr_ff      <= ptr_in;
         pend_vld_ff <= pend_vld_in;
         start_ff    <= start_in;
         timeout_ff  <= timeout_in;
         mode_ff     <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
   end

endmodule

@@ bench/tb_software_timer_bank_unit.sv @@
// ----------------------------------------------------------------------------
// tb_software_timer_bank_unit
// Self-checking bench for the software timer bank. A queue of pending
// commands feeds a clocked driver; each accepted item updates a local copy of
// the tick counter and timer store, and scans push their expected expiries.
// A clocked monitor compares every strobed result with the oldest expiry.
// ----------------------------------------------------------------------------
module tb_software_timer_bank_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import stb_pkg::*;

   localparam int CLOCK_HALF  = 10;
   localparam int RESET_LEN   = 10;
   localparam int RANDOM_LEN  = 445;
   localparam int DRAIN_LEN   = 20;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Local copy of the bank
   logic [TICK_WIDTH-1:0]    tick_copy;
   logic [TICK_WIDTH-1:0]    start_copy   [MAX_TIMERS];
   logic [TIMEOUT_WIDTH-1:0] timeout_copy [MAX_TIMERS];
   logic                     mode_copy    [MAX_TIMERS];

   req_type pending_cmds[$];
   rsp_type expiry_queue[$];
   bit      in_flight = 1'b0;
   bit      failed = 1'b0;
   int      accepted_count = 0;
   int      cycle_count = 0;

   software_timer_bank_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic req_type make_cmd(op_type op, int idx, logic [TIMEOUT_WIDTH-1:0] tmo,
                                        logic per);
      req_type cmd;
      cmd.op            = op;
      cmd.timer_index   = INDEX_WIDTH'(idx);
      cmd.timeout_ticks = tmo;
      cmd.periodic      = per;
      return cmd;
   endfunction

   // Apply one command to the local bank and queue any expiries it reports
   task automatic apply_timer_cmd(input req_type cmd);
      rsp_type hit;
      int      n;
      n = 0;
      case (cmd.op)
         OP_START: begin
            mode_copy[cmd.timer_index]    = cmd.periodic;
            timeout_copy[cmd.timer_index] = cmd.timeout_ticks;
            start_copy[cmd.timer_index]   = tick_copy;
         end
         OP_STOP: begin
            timeout_copy[cmd.timer_index] = '0;
         end
         OP_TICK: begin
            tick_copy = tick_copy + 1'b1;
         end
         default: begin
            for (int i = 0; i < MAX_TIMERS; i++) begin
               if (timeout_copy[i] != '0 &&
                   (tick_copy - start_copy[i]) >= TICK_WIDTH'(timeout_copy[i])) begin
                  hit.fired_index = INDEX_WIDTH'(i);
                  hit.fired       = 1'b1;
                  hit.last        = 1'b0;
                  expiry_queue.push_back(hit);
                  n++;
                  if (mode_copy[i])
                     start_copy[i] = tick_copy;
                  else
                     timeout_copy[i] = '0;
               end
            end
            // Report an empty scan as a single result with no fire
            if (n == 0) begin
               hit = '0;
               expiry_queue.push_back(hit);
            end
            expiry_queue[$].last = 1'b1;
         end
      endcase
   endtask

   // Record accepted items and advance the local bank
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         apply_timer_cmd(req_data);
         void'(pending_cmds.pop_front());
         in_flight = 1'b0;
         accepted_count++;
      end
   end

   // Present the next item, idling at random outside the quiet stretch
   always @(negedge clock) begin
      bit quiet;
      quiet = (accepted_count >= 200 && accepted_count < 300);
      if (reset) begin
         start <= 1'b0;
      end else if (!in_flight) begin
         if (pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
            start     <= 1'b1;
            req_data  <= pending_cmds[0];
            in_flight = 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Compare each strobed result with the oldest expiry
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expiry_queue.size() == 0) begin
            $error("unexpected result: fired_index %0d fired %0d last %0d",
                   rsp_data.fired_index, rsp_data.fired, rsp_data.last);
            failed = 1'b1;
         end else begin
            want = expiry_queue.pop_front();
            if (rsp_data.fired_index !== want.fired_index) begin
               $error("fired_index: expected %0d, actual %0d",
                      want.fired_index, rsp_data.fired_index);
               failed = 1'b1;
            end
            if (rsp_data.fired !== want.fired) begin
               $error("fired: expected %0d, actual %0d", want.fired, rsp_data.fired);
               failed = 1'b1;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               failed = 1'b1;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("software_timer_bank_unit: mismatch");
         $finish;
      end
   end

   initial begin
      int                       r;
      op_type                   op;
      logic [TIMEOUT_WIDTH-1:0] tmo;

      tick_copy = '0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         start_copy[i]   = '0;
         timeout_copy[i] = '0;
         mode_copy[i]    = 1'b0;
      end

      // Directed: empty scan, one-shot, zero timeout, periodic restart, stop,
      // widest timeout, and every timer expiring in one scan
      pending_cmds.push_back(make_cmd(OP_SCAN, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_START, 0, 24'd1, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCAN, 7, '1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_TICK, 7, '1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_SCAN, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCAN, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_START, 7, '1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_START, 3, '0, 1'b1));
      pending_cmds.push_back(make_cmd(OP_START, 5, 24'd2, 1'b1));
      pending_cmds.push_back(make_cmd(OP_TICK, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_TICK, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCAN, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_TICK, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_TICK, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCAN, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_STOP, 5, '1, 1'b1));
      pending_cmds.push_back(make_cmd(OP_STOP, 7, '0, 1'b0));
      for (int i = 0; i < MAX_TIMERS; i++)
         pending_cmds.push_back(make_cmd(OP_START, i, 24'd1, i[0]));
      pending_cmds.push_back(make_cmd(OP_TICK, 0, '0, 1'b0));
      pending_cmds.push_back(make_cmd(OP_SCAN, 0, '0, 1'b0));

      // Random: mostly short timeouts so that ticks bring them to expiry
      for (int k = 0; k < RANDOM_LEN; k++) begin
         r = $urandom_range(99);
         if (r < 25)
            op = OP_START;
         else if (r < 35)
            op = OP_STOP;
         else if (r < 75)
            op = OP_TICK;
         else
            op = OP_SCAN;
         r = $urandom_range(99);
         if (op != OP_START)
            tmo = TIMEOUT_WIDTH'($urandom());
         else if (r < 5)
            tmo = '0;
         else if (r < 10)
            tmo = TIMEOUT_WIDTH'($urandom());
         else if (r < 12)
            tmo = '1;
         else
            tmo = TIMEOUT_WIDTH'($urandom_range(12, 1));
         pending_cmds.push_back(make_cmd(op, $urandom_range(MAX_TIMERS - 1), tmo,
                                         1'($urandom_range(1))));
      end

      repeat (RESET_LEN) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain, then allow the back end to settle
      while (pending_cmds.size() != 0 || in_flight || expiry_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_LEN) @(posedge clock);

      if (expiry_queue.size() != 0) begin
         $error("%0d expected results never arrived", expiry_queue.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("software_timer_bank_unit: match");
      end else begin
         $display("software_timer_bank_unit: mismatch");
      end
      $finish;
   end

endmodule
